FILE: design/chsp_pkg.sv
package chsp_pkg;

    localparam int NAME_COUNT = 11;
    localparam int NIB_COUNT  = 8;

    // Bits of the invalid-digit flags: digits 1-3, 4-6 and 7-8
    localparam int BAD_GRP_RGB3  = 0;
    localparam int BAD_GRP_RGB6  = 1;
    localparam int BAD_GRP_ALPHA = 2;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [31:0] ARGB_NONE   = 32'h0000_0000;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // One character of the string with its end-of-string marker
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } item_t;

    // Name text, one row per name, padded with NUL to sixteen columns
    typedef logic [7:0] name_row_t [16];

    localparam name_row_t NAME_TEXT [NAME_COUNT] = '{
        '{8'h74, 8'h72, 8'h61, 8'h6E, 8'h73, 8'h70, 8'h61, 8'h72,
          8'h65, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // transparent
        '{8'h62, 8'h6C, 8'h61, 8'h63, 8'h6B, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // black
        '{8'h77, 8'h68, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // white
        '{8'h72, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // red
        '{8'h67, 8'h72, 8'h65, 8'h65, 8'h6E, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // green
        '{8'h62, 8'h6C, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // blue
        '{8'h79, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h77, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // yellow
        '{8'h63, 8'h79, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // cyan
        '{8'h6D, 8'h61, 8'h67, 8'h65, 8'h6E, 8'h74, 8'h61, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // magenta
        '{8'h67, 8'h72, 8'h61, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // gray
        '{8'h67, 8'h72, 8'h65, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // grey
    };

    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd11, 4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7, 4'd4, 4'd4
    };

    localparam logic [31:0] NAME_COLOR [NAME_COUNT] = '{
        32'h0000_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
        32'hFF00_FF00, 32'hFF00_00FF, 32'hFFFF_FF00, 32'hFF00_FFFF,
        32'hFFFF_00FF, 32'hFF80_8080, 32'hFF80_8080
    };

    // Hex digit value in the low four bits; bit 4 set for a non-digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

FILE: design/chsp_core.sv
module chsp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_fire,
    input  chsp_pkg::item_t     item,
    output logic [31:0]         argb
);
    import chsp_pkg::*;

    logic [3:0]            char_count_reg, char_count_next, cnt_upd;
    logic                  hex_mode_reg, hex_mode_next, hex_upd;
    logic [NAME_COUNT-1:0] name_alive_reg, name_alive_next, alive_upd;
    logic [2:0]            bad_flags_reg, bad_flags_next, bad_upd;
    logic                  ended_reg, ended_next, ended_upd;
    logic [3:0]            nib_reg [NIB_COUNT];
    logic [3:0]            nib_upd [NIB_COUNT];
    logic                  nib_wr;
    logic [2:0]            nib_idx;
    logic [4:0]            dval;
    logic [7:0]            lc;

    assign dval    = digit_value(item.character);
    assign lc      = to_lower(item.character);
    assign nib_idx = 3'(char_count_reg - 4'd1);

    // Fold one character into the string state
    always_comb begin
        cnt_upd   = char_count_reg;
        hex_upd   = hex_mode_reg;
        alive_upd = name_alive_reg;
        bad_upd   = bad_flags_reg;
        ended_upd = ended_reg;
        nib_wr    = 1'b0;
        if (item_fire && !ended_reg) begin
            if (item.character == CHAR_NUL) begin
                ended_upd = 1'b1;
            end else begin
                if (char_count_reg == 4'd0 && item.character == CHAR_HASH) begin
                    hex_upd = 1'b1;
                end
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (char_count_reg >= NAME_LEN[i] ||
                        NAME_TEXT[i][char_count_reg] != lc) begin
                        alive_upd[i] = 1'b0;
                    end
                end
                if (hex_upd && char_count_reg >= 4'd1 && char_count_reg <= 4'd8) begin
                    nib_wr = 1'b1;
                    if (dval[4]) begin
                        priority if (char_count_reg <= 4'd3) begin
                            bad_upd[BAD_GRP_RGB3] = 1'b1;
                        end else if (char_count_reg <= 4'd6) begin
                            bad_upd[BAD_GRP_RGB6] = 1'b1;
                        end else begin
                            bad_upd[BAD_GRP_ALPHA] = 1'b1;
                        end
                    end
                end
                if (char_count_reg != 4'd15) begin
                    cnt_upd = char_count_reg + 4'd1;
                end
            end
        end
    end

    // Nibble store with the current write folded in
    always_comb begin
        for (int i = 0; i < NIB_COUNT; i++) begin
            nib_upd[i] = (nib_wr && nib_idx == 3'(i)) ? dval[3:0] : nib_reg[i];
        end
    end

    // Work out the colour from the updated state
    always_comb begin
        logic [3:0] digits;
        logic [7:0] alpha;
        argb   = ARGB_NONE;
        digits = (cnt_upd == 4'd0) ? 4'd0 : cnt_upd - 4'd1;
        alpha  = ALPHA_OPAQUE;
        if (hex_upd) begin
            if (digits == 4'd3) begin
                if (!bad_upd[BAD_GRP_RGB3]) begin
                    argb = {ALPHA_OPAQUE, nib_upd[0], nib_upd[0], nib_upd[1], nib_upd[1],
                            nib_upd[2], nib_upd[2]};
                end
            end else if (digits >= 4'd6) begin
                if (digits >= 4'd8) begin
                    alpha = {nib_upd[6], nib_upd[7]};
                end
                if (!bad_upd[BAD_GRP_RGB3] && !bad_upd[BAD_GRP_RGB6] &&
                    !(digits >= 4'd8 && bad_upd[BAD_GRP_ALPHA])) begin
                    argb = {alpha, nib_upd[0], nib_upd[1], nib_upd[2], nib_upd[3],
                            nib_upd[4], nib_upd[5]};
                end
            end
        end else begin
            // lowest-numbered matching name wins
            for (int i = NAME_COUNT - 1; i >= 0; i--) begin
                if (alive_upd[i] && cnt_upd == NAME_LEN[i]) begin
                    argb = NAME_COLOR[i];
                end
            end
        end
    end

    // Return to the idle state after the last character
    always_comb begin
        if (item_fire && item.last) begin
            char_count_next = 4'd0;
            hex_mode_next   = 1'b0;
            name_alive_next = '1;
            bad_flags_next  = 3'd0;
            ended_next      = 1'b0;
        end else begin
            char_count_next = cnt_upd;
            hex_mode_next   = hex_upd;
            name_alive_next = alive_upd;
            bad_flags_next  = bad_upd;
            ended_next      = ended_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= 4'd0;
            hex_mode_reg   <= 1'b0;
            name_alive_reg <= '1;
            bad_flags_reg  <= 3'd0;
            ended_reg      <= 1'b0;
        end else begin
            char_count_reg <= char_count_next;
            hex_mode_reg   <= hex_mode_next;
            name_alive_reg <= name_alive_next;
            bad_flags_reg  <= bad_flags_next;
            ended_reg      <= ended_next;
        end
    end

    // Hold digit nibbles; no reset needed
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NIB_COUNT; i++) begin
            nib_reg[i] <= nib_upd[i];
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item.last |=> char_count_reg == 4'd0 && !hex_mode_reg &&
                                   name_alive_reg == '1 && bad_flags_reg == 3'd0 && !ended_reg)
        else $error("string state not cleared after last character");

    a_hex_kills_names: assert property (@(posedge aclk) disable iff (!aresetn)
        hex_mode_reg |-> name_alive_reg == '0)
        else $error("name still alive in hex mode");

    a_flags_only_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        !hex_mode_reg |-> bad_flags_reg == 3'd0)
        else $error("digit flags set outside hex mode");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        char_count_reg == 4'd15 && item_fire && !item.last |=> char_count_reg == 4'd15)
        else $error("character count wrapped");

endmodule

FILE: design/hex_color_string_parser.sv
// Colour string parser: takes a colour string one character per transaction on the
// s_ side and returns one packed ARGB word on the m_ side for each transaction marked
// tlast. A leading '#' selects hex (3, 6, 7 or 8+ digits); otherwise the string is
// matched case-insensitively against eleven names. Unrecognised strings give zero.
// A character is taken every cycle unless stalled: the string state is updated behind
// an input register, so throughput is one character per clock, and the result is
// registered as its last character leaves the input register, then waits in the
// output register, not stopping further input until a second result needs that slot.
module hex_color_string_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] argb
);
    import chsp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        proc_fire;
    logic [31:0] argb;
    logic        out_valid_next;

    // Advance a held character unless its result has nowhere to go
    assign proc_fire = in_valid_reg && (!in_item_reg.last || !m_tvalid || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = m_tvalid;
        if (proc_fire && in_item_reg.last) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid     <= out_valid_next;
        end
    end

    // Capture input and result payloads
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{character: s_tdata, last: s_tlast};
        end
        if (proc_fire && in_item_reg.last) begin
            m_tdata <= argb;
        end
    end

    chsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (proc_fire),
        .item      (in_item_reg),
        .argb      (argb)
    );

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_item_reg.last |=> m_tvalid)
        else $error("result not presented after last character");

    a_stall_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && in_valid_reg && in_item_reg.last |-> !s_tready)
        else $error("input taken while result slot blocked");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule

FILE: tb/sv/hex_color_string_parser_test.sv
`timescale 1ns / 1ps

module hex_color_string_parser_test;
    import chsp_pkg::*;

    // Hex digit value in the low four bits; bit 4 set for anything that is not a digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    // Tracks the parser state per character and holds the colours still owed
    class color_scoreboard;
        logic [31:0] expected_colors[$];
        int unsigned fails;

        logic [3:0]  char_count;
        bit          hex_mode;
        logic [10:0] name_alive;
        logic [3:0]  nibbles[NIB_COUNT];
        logic [2:0]  bad_groups;
        bit          string_ended;

        function new();
            fails = 0;
            clear_string();
        endfunction

        function void clear_string();
            char_count   = 4'd0;
            hex_mode     = 1'b0;
            name_alive   = '1;
            bad_groups   = 3'b000;
            string_ended = 1'b0;
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        // Colour owed for the string gathered so far
        function logic [31:0] color_of();
            logic [3:0] digits;
            logic [7:0] alpha;
            int i;
            if (hex_mode) begin
                digits = (char_count >= 4'd1) ? char_count - 4'd1 : 4'd0;
                if (digits == 4'd3) begin
                    if (bad_groups[BAD_GRP_RGB3]) return ARGB_NONE;
                    return {ALPHA_OPAQUE, nibbles[0], nibbles[0], nibbles[1], nibbles[1],
                            nibbles[2], nibbles[2]};
                end
                if (digits < 4'd6 || bad_groups[BAD_GRP_RGB3] ||
                    bad_groups[BAD_GRP_RGB6]) begin
                    return ARGB_NONE;
                end
                alpha = ALPHA_OPAQUE;
                if (digits >= 4'd8) begin
                    if (bad_groups[BAD_GRP_ALPHA]) return ARGB_NONE;
                    alpha = {nibbles[6], nibbles[7]};
                end
                return {alpha, nibbles[0], nibbles[1], nibbles[2], nibbles[3],
                        nibbles[4], nibbles[5]};
            end
            for (i = 0; i < NAME_COUNT; i++) begin
                if (name_alive[i] && char_count == NAME_LEN[i]) return NAME_COLOR[i];
            end
            return ARGB_NONE;
        endfunction

        // Advance the state by one accepted character transaction
        function void note_char(input logic [7:0] ch, input logic last);
            logic [3:0] pos;
            logic [7:0] folded;
            logic [4:0] value;
            logic [2:0] slot;
            int i;
            if (!string_ended) begin
                if (ch == CHAR_NUL) begin
                    string_ended = 1'b1;
                end else begin
                    pos    = char_count;
                    folded = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;
                    if (pos == 4'd0 && ch == CHAR_HASH) hex_mode = 1'b1;
                    for (i = 0; i < NAME_COUNT; i++) begin
                        if (pos >= NAME_LEN[i] || NAME_TEXT[i][pos] != folded) begin
                            name_alive[i] = 1'b0;
                        end
                    end
                    if (hex_mode && pos >= 4'd1 && pos <= 4'd8) begin
                        slot  = 3'(pos - 4'd1);
                        value = nibble_of(ch);
                        if (value[4]) begin
                            if (slot < 3'd3) bad_groups[BAD_GRP_RGB3] = 1'b1;
                            else if (slot < 3'd6) bad_groups[BAD_GRP_RGB6] = 1'b1;
                            else bad_groups[BAD_GRP_ALPHA] = 1'b1;
                        end
                        nibbles[slot] = value[3:0];
                    end
                    if (char_count != 4'd15) char_count = char_count + 4'd1;
                end
            end
            if (last) begin
                expected_colors.push_back(color_of());
                clear_string();
            end
        endfunction

        // Compare one returned colour with the oldest one owed
        function void check_color(input logic [31:0] got);
            logic [31:0] want;
            if (expected_colors.size() == 0) begin
                fails++;
                if (fails <= 10) $display("colour %h returned with none owed", got);
                return;
            end
            want = expected_colors.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= 10) $display("colour mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    localparam int HEX_LENGTHS [18] = '{0, 1, 2, 3, 3, 3, 4, 5, 6, 6, 6, 7, 8, 8, 8, 9, 12, 16};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] character
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] argb

    color_scoreboard sb;
    logic [7:0]  str_buf[$];
    int          items_sent = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_left = 0;

    hex_color_string_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check results and stall the result channel in changing patterns
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_color(m_tdata);
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_left[2:0] != 3'd0);
        endcase
    end

    task automatic idle(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold the input until the parser has returned every colour owed
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(ch, last);
        items_sent++;
    endtask

    // Send the buffered string in bursts, last marked on its final character
    task automatic send_text();
        int k;
        for (k = 0; k < str_buf.size(); k++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                        : $urandom_range(1, 16);
            end
            burst_left--;
            send_char(str_buf[k], k == str_buf.size() - 1);
        end
    endtask

    task automatic load_text(input string s);
        int k;
        str_buf.delete();
        for (k = 0; k < s.len(); k++) str_buf.push_back(s[k]);
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'h30 + 8'(v);
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] letter();
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    // Build one random string: mostly hex or names, some noise and broken strings
    task automatic build_random();
        logic [7:0] c;
        logic [4:0] v;
        int n, bad_at, k, pick;
        str_buf.delete();
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            str_buf.push_back(CHAR_HASH);
            n = HEX_LENGTHS[$urandom_range(0, 17)];
            bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : -1;
            for (k = 0; k < n; k++) begin
                if (k == bad_at) begin
                    do begin
                        c = 8'($urandom_range(1, 255));
                        v = nibble_of(c);
                    end while (!v[4]);
                    str_buf.push_back(c);
                end else begin
                    str_buf.push_back(hex_char());
                end
            end
        end else if (pick <= 7) begin
            n = $urandom_range(0, NAME_COUNT - 1);
            for (k = 0; k < NAME_LEN[n]; k++) begin
                c = NAME_TEXT[n][k];
                if ($urandom_range(0, 1) != 0) c = c - 8'h20;
                str_buf.push_back(c);
            end
            case ($urandom_range(0, 7))
                0: void'(str_buf.pop_back());
                1: str_buf.push_back(letter());
                2: str_buf[$urandom_range(0, str_buf.size() - 1)] = letter();
                default: ;
            endcase
        end else begin
            n = $urandom_range(1, 20);
            for (k = 0; k < n; k++) begin
                c = ($urandom_range(0, 29) == 0) ? CHAR_NUL : 8'($urandom_range(1, 255));
                str_buf.push_back(c);
            end
        end
        // Terminate early now and then, with junk after the terminator
        if ($urandom_range(0, 7) == 0) begin
            str_buf.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (str_buf.size() == 0 || $urandom_range(0, 30) == 0) str_buf = '{CHAR_NUL};
    endtask

    initial begin
        int strings;
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: short hex, mixed-case name, empty, eight digits, high byte, early end
        load_text("#a1F");
        send_text();
        load_text("bLuE");
        send_text();
        str_buf = '{CHAR_NUL};
        send_text();
        load_text("#0Fe8c9A7");
        send_text();
        str_buf = '{8'hFF};
        send_text();
        load_text("r");
        str_buf.push_back(CHAR_NUL);
        str_buf.push_back(8'h65);
        str_buf.push_back(8'h64);
        send_text();
        drain();

        // Random strings, with a full drain now and then
        strings = 0;
        while (items_sent < RANDOM_ITEMS + 25) begin
            build_random();
            send_text();
            strings++;
            if (strings % 40 == 20) drain();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) $display("%0d colours never returned", sb.pending());
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
